// ----- hw/rtl/zbf_pkg.sv -----
// zbf_pkg: shared types and constants for the z-buffer framebuffer
// beat structs, item kinds, register indexes and the store port bundle
// no dependencies
`default_nettype none

package zbf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int SIZE_W     = 9;
    localparam int COLOR_W    = 32;
    localparam int DEPTH_W    = 16;

    localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);
    localparam logic signed [DEPTH_W-1:0] DEPTH_MINUS_ONE = 16'sh8000;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_TEST  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_DEPTH_EN  = 2'd2,
        CFG_FILL      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_kind                      kind;
        logic [7:0]                 pos_x;
        logic [7:0]                 pos_y;
        logic signed [DEPTH_W-1:0]  frag_depth;
        logic [COLOR_W-1:0]         pixel_color;
        logic                       clear_colors;
        logic                       clear_depths;
    } t_px;

    typedef struct packed {
        logic                passed;
        logic [COLOR_W-1:0]  read_color;
        logic                coord_error;
    } t_res;

    typedef struct packed {
        logic                       rd_en;
        logic [ADDR_W-1:0]          raddr;
        logic                       c_we;
        logic                       d_we;
        logic [ADDR_W-1:0]          waddr;
        logic [COLOR_W-1:0]         wcolor;
        logic signed [DEPTH_W-1:0]  wdepth;
    } t_mem_req;

endpackage

`default_nettype wire

// ----- hw/rtl/zbf_store.sv -----
// zbf_store: color and depth stores, one write port and one read port each
// read data is registered
// depends on zbf_pkg
`default_nettype none

module zbf_store
    import zbf_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire t_mem_req                   i_req,
    output logic [COLOR_W-1:0]              o_rcolor,
    output logic signed [DEPTH_W-1:0]       o_rdepth
);

    logic [COLOR_W-1:0]         color_mem [MAX_WIDTH*MAX_HEIGHT];
    logic signed [DEPTH_W-1:0]  depth_mem [MAX_WIDTH*MAX_HEIGHT];
    logic [COLOR_W-1:0]         r_rcolor;
    logic signed [DEPTH_W-1:0]  r_rdepth;

    always_ff @(posedge i_clk) begin
        if (i_req.c_we) begin
            color_mem[i_req.waddr] <= i_req.wcolor;
        end
        if (i_req.rd_en) begin
            r_rcolor <= color_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.d_we) begin
            depth_mem[i_req.waddr] <= i_req.wdepth;
        end
        if (i_req.rd_en) begin
            r_rdepth <= depth_mem[i_req.raddr];
        end
    end

    assign o_rcolor = r_rcolor;
    assign o_rdepth = r_rdepth;

endmodule

`default_nettype wire

// ----- hw/rtl/zbuffer_framebuffer.sv -----
// zbuffer_framebuffer: top level, item sequencer, config registers, result register
// depends on zbf_pkg and zbf_store
`default_nettype none

// Raster back end with a 256x256 color store and depth store; pixel (x, y) sits at
// (height-1-y)*width+x, so row 0 is the bottom row. After reset the block sweeps the
// color store to zero and holds o_px_stall high meanwhile. A depth test, color write
// or color read goes from accept to result through address and store read, compare and
// write back, and the result register; o_px_stall keeps only one item in flight at a
// time. An out-of-range item skips the compare and write back and goes straight to the
// result register. A clear sweeps width*height pixels, one pixel written per cycle.
// Depths are cleared only while the depth test is enabled: enable it, then clear depths
// before testing. The result register frees the input side while a result waits to be
// taken.
module zbuffer_framebuffer
    import zbf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_px_valid,
    output logic            o_px_stall,
    input  wire t_px        i_px,
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output t_res            o_res,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire t_cfg_idx   i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_CLEAR  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [SIZE_W-1:0]  r_width, r_height;
    logic               r_depth_en;
    logic [COLOR_W-1:0] r_fill;

    t_kind                      r_kind;
    logic signed [DEPTH_W-1:0]  r_depth;
    logic [COLOR_W-1:0]         r_color;
    logic [ADDR_W-1:0]          r_addr;
    logic                       r_err;
    logic                       r_clr_c, r_clr_d;
    logic [ADDR_W-1:0]          r_last;
    logic [ADDR_W-1:0]          r_cnt, n_cnt;
    t_res                       r_pend, n_pend;
    t_res                       r_res;
    logic                       r_res_valid, n_res_valid;

    logic [SIZE_W-1:0]          w_w, w_h;
    logic [7:0]                 row;
    logic [ADDR_W:0]            prod;
    logic [ADDR_W:0]            total;
    logic [ADDR_W-1:0]          acc_addr;
    logic                       acc_err;
    logic                       px_acc;
    logic                       out_free;
    logic                       gt;
    t_mem_req                   mem_req;
    logic [COLOR_W-1:0]         rd_color;
    logic signed [DEPTH_W-1:0]  rd_depth;

    // effective frame size
    always_comb begin
        if (r_width == '0) begin
            w_w = SIZE_W'(1);
        end else if (r_width > MAX_W_SZ) begin
            w_w = MAX_W_SZ;
        end else begin
            w_w = r_width;
        end
        if (r_height == '0) begin
            w_h = SIZE_W'(1);
        end else if (r_height > MAX_H_SZ) begin
            w_h = MAX_H_SZ;
        end else begin
            w_h = r_height;
        end
    end

    assign o_px_stall  = (r_state != S_IDLE);
    assign px_acc      = i_px_valid && !o_px_stall;
    assign o_cfg_ready = 1'b1;

    assign acc_err  = ({1'b0, i_px.pos_x} >= w_w) || ({1'b0, i_px.pos_y} >= w_h);
    assign row      = 8'(w_h - SIZE_W'(1) - {1'b0, i_px.pos_y});
    assign prod     = {9'd0, row} * {8'd0, w_w};
    assign acc_addr = ADDR_W'(prod + {9'd0, i_px.pos_x});
    assign total    = {8'd0, w_w} * {8'd0, w_h};

    assign gt       = (r_depth > rd_depth);
    assign out_free = !r_res_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= MAX_W_SZ;
            r_height   <= MAX_H_SZ;
            r_depth_en <= 1'b0;
            r_fill     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH:    r_width    <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[SIZE_W-1:0];
                CFG_DEPTH_EN: r_depth_en <= i_cfg_data[0];
                CFG_FILL:     r_fill     <= i_cfg_data;
                default:      r_fill     <= r_fill;
            endcase
        end
    end

    // store port requests
    always_comb begin
        mem_req        = '0;
        mem_req.rd_en  = px_acc;
        mem_req.raddr  = acc_addr;
        mem_req.waddr  = r_addr;
        mem_req.wcolor = r_color;
        mem_req.wdepth = r_depth;
        unique case (r_state)
            S_INIT: begin
                mem_req.c_we   = 1'b1;
                mem_req.waddr  = r_cnt;
                mem_req.wcolor = '0;
            end
            S_EXEC: begin
                mem_req.c_we = (r_kind == KIND_WRITE);
                mem_req.d_we = (r_kind == KIND_TEST) && r_depth_en && gt;
            end
            S_CLEAR: begin
                mem_req.c_we   = r_clr_c;
                mem_req.d_we   = r_clr_d;
                mem_req.waddr  = r_cnt;
                mem_req.wcolor = r_fill;
                mem_req.wdepth = DEPTH_MINUS_ONE;
            end
            S_IDLE, S_RESULT: begin
                mem_req.c_we = 1'b0;
            end
            default: begin
                mem_req.c_we = 1'b0;
            end
        endcase
    end

    zbf_store u_store (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rcolor (rd_color),
        .o_rdepth (rd_depth)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_res_valid = r_res_valid && i_res_stall;
        unique case (r_state)
            S_INIT: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (px_acc) begin
                    n_pend = '0;
                    n_cnt  = '0;
                    if (i_px.kind == KIND_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if (acc_err) begin
                        n_pend.coord_error = 1'b1;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_pend.passed      = (r_kind == KIND_TEST) && (!r_depth_en || gt);
                n_pend.read_color  = (r_kind == KIND_READ) ? rd_color : '0;
                n_pend.coord_error = 1'b0;
                n_state            = S_RESULT;
            end
            S_CLEAR: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == r_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (px_acc) begin
            r_kind  <= i_px.kind;
            r_depth <= i_px.frag_depth;
            r_color <= i_px.pixel_color;
            r_addr  <= acc_addr;
            r_err   <= acc_err;
            r_clr_c <= i_px.clear_colors;
            r_clr_d <= i_px.clear_depths && r_depth_en;
            r_last  <= ADDR_W'(total - 17'd1);
        end
        if (r_state == S_RESULT && out_free) begin
            r_res <= r_pend;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_exec_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_err)
        else $error("store access for an out-of-range pixel");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        px_acc |=> (r_state == S_EXEC || r_state == S_CLEAR || r_state == S_RESULT))
        else $error("accepted beat did not start work");

    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_cnt <= r_last))
        else $error("clear sweep ran past the frame");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.c_we || mem_req.d_we)
            |-> (r_state == S_INIT || r_state == S_EXEC || r_state == S_CLEAR))
        else $error("store write outside a writing state");

    a_pass_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.passed) |-> (!o_res.coord_error && o_res.read_color == '0))
        else $error("passed beat carries error or color");
`endif

endmodule

`default_nettype wire

// ----- test/zbuffer_framebuffer_test.sv -----
// zbuffer_framebuffer_test: self-checking bench for the z-buffer framebuffer
// drives pixel beats and register writes, predicts every result beat and compares it
// depends on zbf_pkg and zbuffer_framebuffer
`default_nettype none

module zbuffer_framebuffer_test;
    import zbf_pkg::*;

    localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
    localparam int ITEMS_PER_MODE = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        px_valid = 1'b0;
    t_px         px_beat = '0;
    logic        res_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    t_cfg_idx    cfg_index = CFG_WIDTH;
    logic [31:0] cfg_data = '0;
    logic        px_stall;
    logic        res_valid;
    logic        cfg_ready;
    t_res        res_beat;

    zbuffer_framebuffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_px_valid  (px_valid),
        .o_px_stall  (px_stall),
        .i_px        (px_beat),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predicted frame state
    logic [8:0]         width_reg = 9'd256;
    logic [8:0]         height_reg = 9'd256;
    logic               depth_on = 1'b0;
    logic [31:0]        fill_reg = '0;
    logic [31:0]        color_mem [NPIX];
    logic signed [15:0] depth_mem [NPIX];
    bit                 depth_written [NPIX];
    t_res               owed_results [$];

    int send_gap_pct = 11;
    int stall_pct = 49;
    int hold_req = 0;
    int hold_left = 0;
    int failures = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int clamp_size(input logic [8:0] raw, input int top);
        if (raw == 0) return 1;
        if (int'(raw) > top) return top;
        return int'(raw);
    endfunction

    function automatic int pixel_addr(input logic [7:0] x, input logic [7:0] y);
        return (clamp_size(height_reg, MAX_HEIGHT) - 1 - int'(y))
               * clamp_size(width_reg, MAX_WIDTH) + int'(x);
    endfunction

    function automatic t_px px_item(input t_kind k, input int x, input int y, input int d,
                                    input logic [31:0] c, input logic cc, input logic cd);
        t_px p;
        p.kind = k;
        p.pos_x = 8'(x);
        p.pos_y = 8'(y);
        p.frag_depth = 16'(d);
        p.pixel_color = c;
        p.clear_colors = cc;
        p.clear_depths = cd;
        return p;
    endfunction

    // applies one pixel beat to the predicted frame and returns its result
    function automatic t_res zbuffer_outcome(input t_px px);
        t_res r;
        int w;
        int h;
        int a;
        r = '0;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (px.kind == KIND_CLEAR) begin
            for (int i = 0; i < w * h; i++) begin
                if (px.clear_colors) color_mem[i] = fill_reg;
                if (px.clear_depths && depth_on) begin
                    depth_mem[i] = DEPTH_MINUS_ONE;
                    depth_written[i] = 1'b1;
                end
            end
        end else if (int'(px.pos_x) >= w || int'(px.pos_y) >= h) begin
            r.coord_error = 1'b1;
        end else begin
            a = pixel_addr(px.pos_x, px.pos_y);
            case (px.kind)
                KIND_TEST: begin
                    if (!depth_on) begin
                        r.passed = 1'b1;
                    end else if (px.frag_depth > depth_mem[a]) begin
                        depth_mem[a] = px.frag_depth;
                        r.passed = 1'b1;
                    end
                end
                KIND_WRITE: color_mem[a] = px.pixel_color;
                default: r.read_color = color_mem[a];
            endcase
        end
        return r;
    endfunction

    function automatic void log_failure(input string msg);
        failures++;
        if (failures <= 10) $display("%s", msg);
    endfunction

    task automatic send_px(input t_px px);
        if ($urandom_range(99) < send_gap_pct) begin
            px_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        owed_results.push_back(zbuffer_outcome(px));
        px_valid <= 1'b1;
        px_beat <= px;
        @(posedge i_clk);
        while (px_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        px_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_WIDTH:    width_reg = val[8:0];
            CFG_HEIGHT:   height_reg = val[8:0];
            CFG_DEPTH_EN: depth_on = val[0];
            default:      fill_reg = val;
        endcase
    endtask

    task automatic set_frame(input logic [8:0] w, input logic [8:0] h, input logic den,
                             input logic [31:0] fill);
        drain();
        write_reg(CFG_WIDTH, {23'd0, w});
        write_reg(CFG_HEIGHT, {23'd0, h});
        write_reg(CFG_DEPTH_EN, {31'd0, den});
        write_reg(CFG_FILL, fill);
        cfg_valid <= 1'b0;
    endtask

    // receiver: long hold on request, otherwise random stall
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left <= hold_req;
            hold_req = 0;
            res_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_valid && !res_stall) begin
            if (owed_results.size() == 0) begin
                log_failure($sformatf("result beat with nothing pending: %p", res_beat));
            end else begin
                want = owed_results.pop_front();
                if (res_beat.passed !== want.passed || res_beat.read_color !== want.read_color
                        || res_beat.coord_error !== want.coord_error)
                    log_failure($sformatf({"result mismatch: expected passed %b color %h ",
                        "error %b, got passed %b color %h error %b"},
                        want.passed, want.read_color, want.coord_error,
                        res_beat.passed, res_beat.read_color, res_beat.coord_error));
            end
        end
    end

    task automatic test_reset_contents();
        send_px(px_item(KIND_READ, 0, 0, 0, 0, 0, 0));
        send_px(px_item(KIND_READ, 255, 255, 0, 0, 0, 0));
        send_px(px_item(KIND_WRITE, 255, 255, 0, 32'hFFFF_FFFF, 1, 1));
        send_px(px_item(KIND_WRITE, 0, 0, 0, 32'h8000_0001, 0, 0));
        send_px(px_item(KIND_READ, 255, 255, 0, 0, 0, 0));
        send_px(px_item(KIND_READ, 0, 0, 0, 0, 0, 0));
        send_px(px_item(KIND_TEST, 17, 200, -32768, 0, 0, 0));
    endtask

    task automatic test_size_limits();
        // zero width acts as one column, oversize height as the maximum
        set_frame(9'd0, 9'd511, 1'b0, 32'h0);
        send_px(px_item(KIND_WRITE, 0, 0, 0, 32'h1357_9BDF, 0, 0));
        send_px(px_item(KIND_WRITE, 1, 0, 0, 32'hDEAD_BEEF, 0, 0));
        send_px(px_item(KIND_READ, 0, 255, 0, 0, 0, 0));
        send_px(px_item(KIND_TEST, 200, 5, 0, 0, 0, 0));
        send_px(px_item(KIND_READ, 0, 0, 0, 0, 0, 0));
        set_frame(9'd511, 9'd0, 1'b0, 32'h0);
        send_px(px_item(KIND_READ, 255, 0, 0, 0, 0, 0));
        send_px(px_item(KIND_READ, 0, 1, 0, 0, 0, 0));
    endtask

    task automatic test_depth_compare();
        set_frame(9'd256, 9'd256, 1'b1, 32'hFFFF_FFFF);
        send_px(px_item(KIND_CLEAR, 0, 0, 0, 0, 1, 1));
        // equal depth fails, strictly greater passes
        send_px(px_item(KIND_TEST, 0, 0, -32768, 0, 0, 0));
        send_px(px_item(KIND_TEST, 0, 0, 32767, 0, 0, 0));
        send_px(px_item(KIND_TEST, 0, 0, 32767, 0, 0, 0));
        send_px(px_item(KIND_TEST, 255, 255, -32767, 0, 0, 0));
        send_px(px_item(KIND_READ, 128, 64, 0, 0, 0, 0));
        set_frame(9'd3, 9'd2, 1'b1, 32'h1234_5678);
        send_px(px_item(KIND_CLEAR, 0, 0, 0, 0, 1, 0));
        send_px(px_item(KIND_TEST, 2, 1, 0, 0, 0, 0));
        send_px(px_item(KIND_TEST, 3, 0, 0, 0, 0, 0));
        send_px(px_item(KIND_TEST, 0, 2, 0, 0, 0, 0));
        send_px(px_item(KIND_READ, 2, 1, 0, 0, 0, 0));
    endtask

    task automatic test_depth_kept();
        // depth clear with the test off leaves depths alone
        set_frame(9'd3, 9'd2, 1'b0, 32'h0);
        send_px(px_item(KIND_CLEAR, 0, 0, 0, 0, 1, 1));
        set_frame(9'd3, 9'd2, 1'b1, 32'h0);
        send_px(px_item(KIND_TEST, 2, 1, 0, 0, 0, 0));
        send_px(px_item(KIND_TEST, 2, 1, 1, 0, 0, 0));
    endtask

    task automatic test_backpressure();
        set_frame(9'd16, 9'd16, 1'b0, 32'h0F0F_0F0F);
        hold_req = 400;
        for (int i = 0; i < 40; i++)
            send_px(px_item(i[0] ? KIND_READ : KIND_WRITE, i / 2, 3, 0, $urandom, 0, 0));
        drain();
        for (int i = 0; i < 10; i++)
            send_px(px_item(KIND_READ, i, 3, 0, 0, 0, 0));
    endtask

    task automatic run_random_frames(input int item_goal);
        int sent;
        int w;
        int h;
        int x;
        int y;
        int a;
        int pick;
        int last_x;
        int last_y;
        t_kind k;
        t_px px;
        logic [8:0] wr;
        logic [8:0] hr;
        sent = 0;
        last_x = 0;
        last_y = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(15);
            wr = (pick == 0) ? 9'd0 : (pick == 1) ? 9'd256 : (pick == 2) ? 9'd511
                 : 9'($urandom_range(1, 16));
            pick = $urandom_range(15);
            hr = (pick == 0) ? 9'd0 : (pick == 1) ? 9'd256 : (pick == 2) ? 9'd511
                 : 9'($urandom_range(1, 16));
            set_frame(wr, hr, 1'($urandom_range(1)), $urandom);
            w = clamp_size(wr, MAX_WIDTH);
            h = clamp_size(hr, MAX_HEIGHT);
            if (w * h <= 1024 && $urandom_range(9) != 0) begin
                send_px(px_item(KIND_CLEAR, $urandom_range(255), $urandom_range(255), $urandom,
                                $urandom, 1'($urandom_range(1)), $urandom_range(9) != 0));
                sent++;
            end
            repeat ($urandom_range(8, 60)) begin
                if ($urandom_range(99) < 88) begin
                    x = $urandom_range(w - 1);
                    y = $urandom_range(h - 1);
                end else begin
                    x = $urandom_range(255);
                    y = $urandom_range(255);
                end
                pick = $urandom_range(99);
                if (pick < 3 && w * h <= 1024) begin
                    k = KIND_CLEAR;
                end else if (pick < 40) begin
                    k = KIND_TEST;
                end else if (pick < 70) begin
                    k = KIND_WRITE;
                    last_x = x;
                    last_y = y;
                end else begin
                    k = KIND_READ;
                    if (pick < 85) begin
                        x = last_x;
                        y = last_y;
                    end
                end
                px = px_item(k, x, y, $urandom, $urandom, 1'($urandom_range(1)),
                             1'($urandom_range(1)));
                if (k == KIND_TEST && depth_on && x < w && y < h) begin
                    a = pixel_addr(px.pos_x, px.pos_y);
                    // never compare against a depth that was never written
                    if (!depth_written[a])
                        px.kind = KIND_WRITE;
                    else if ($urandom_range(1))
                        px.frag_depth = 16'(int'(depth_mem[a]) + $urandom_range(4) - 2);
                end
                send_px(px);
                sent++;
            end
        end
    endtask

    initial begin
        foreach (color_mem[i]) begin
            color_mem[i] = '0;
            depth_mem[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_contents();
        test_size_limits();
        test_depth_compare();
        test_depth_kept();
        run_random_frames(ITEMS_PER_MODE);
        drain();
        send_gap_pct = 49;
        stall_pct = 11;
        run_random_frames(ITEMS_PER_MODE);
        drain();
        send_gap_pct = 0;
        stall_pct = 0;
        test_backpressure();
        run_random_frames(ITEMS_PER_MODE);
        drain();
        repeat (16) @(posedge i_clk);
        if (failures == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #36_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
